// ===== rtl/pad_pkg.sv =====
// ----------------------------------------------------------------------------
// pad_pkg
// Shared types, constants and tag tables of the peer announcement parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pad_pkg;

    // Default digit limit of a decimal field
    localparam int MAX_DIGITS_DEF = 20;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VERSION  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NICK_MAX_LEN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_NAME_LEN = 2'd2;

    localparam logic [7:0]  MAX_VERSION_RST  = 8'd4;
    localparam logic [7:0]  NICK_MAX_LEN_RST = 8'd15;
    localparam logic [15:0] MAX_NAME_LEN_RST = 16'd512;

    // Tag lengths
    localparam logic [2:0] HDR_TAG_LEN  = 3'd7;
    localparam logic [2:0] PORT_TAG_LEN = 3'd6;
    localparam logic [2:0] NICK_TAG_LEN = 3'd5;

    // Special characters
    localparam logic [7:0] CH_DICT  = 8'h64; // 'd'
    localparam logic [7:0] CH_END   = 8'h65; // 'e'
    localparam logic [7:0] CH_SEMI  = 8'h3B; // ';'
    localparam logic [7:0] CH_COLON = 8'h3A; // ':'
    localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
    localparam logic [7:0] CH_NINE  = 8'h39; // '9'

    localparam logic [16:0] ACC_MAX = 17'h1FFFF;
    localparam logic [16:0] U16_MAX = 17'h0FFFF;

    typedef enum logic [3:0] {
        PH_HEADER     = 4'd0,
        PH_VERSION    = 4'd1,
        PH_ID         = 4'd2,
        PH_PORT_TAG   = 4'd3,
        PH_PORT_NUM   = 4'd4,
        PH_NICK_TAG   = 4'd5,
        PH_NICK       = 4'd6,
        PH_DICT_START = 4'd7,
        PH_DICT       = 4'd8,
        PH_ENTRY      = 4'd9,
        PH_NAME       = 4'd10
    } t_phase;

    typedef enum logic [3:0] {
        EV_VERSION   = 4'd0,
        EV_ID        = 4'd1,
        EV_PORT      = 4'd2,
        EV_NICK_BYTE = 4'd3,
        EV_NICK_END  = 4'd4,
        EV_LENGTH    = 4'd5,
        EV_NAME_BYTE = 4'd6,
        EV_OK        = 4'd7,
        EV_ERROR     = 4'd8
    } t_event;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_TRUNC = 2'd1,
        ERR_MALF  = 2'd2
    } t_err;

    typedef struct packed {
        logic [7:0]  max_version;
        logic [7:0]  nick_max_len;
        logic [15:0] max_name_len;
    } t_cfg;

    typedef struct packed {
        t_event      kind;
        logic [15:0] value;
        t_err        err;
        logic        same_peer;
        logic        msg_end;
    } t_result;

    // Expected byte of a tag at a position; the phase selects the tag
    function automatic logic [7:0] tag_byte(input t_phase ph, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (ph)
            PH_PORT_TAG: begin
                case (idx)
                    3'd0:    b = 8'h74; // t
                    3'd1:    b = 8'h70; // p
                    3'd2:    b = 8'h6F; // o
                    3'd3:    b = 8'h72; // r
                    3'd4:    b = 8'h74; // t
                    default: b = 8'h3A; // :
                endcase
            end
            PH_NICK_TAG: begin
                case (idx)
                    3'd0:    b = 8'h6E; // n
                    3'd1:    b = 8'h69; // i
                    3'd2:    b = 8'h63; // c
                    3'd3:    b = 8'h6B; // k
                    default: b = 8'h3A; // :
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    b = 8'h50;
                    3'd1:    b = 8'h4C;
                    3'd2:    b = 8'h55;
                    3'd3:    b = 8'h54;
                    3'd4:    b = 8'h4F;
                    3'd5:    b = 8'h5F;
                    default: b = 8'h76;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pad_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pad_cfg_regs
// Configuration register file; write-only, always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pad_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pad_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [pad_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pad_pkg::t_cfg                         o_cfg
);

    pad_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_version  <= pad_pkg::MAX_VERSION_RST;
            r_cfg.nick_max_len <= pad_pkg::NICK_MAX_LEN_RST;
            r_cfg.max_name_len <= pad_pkg::MAX_NAME_LEN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pad_pkg::CFG_MAX_VERSION:  r_cfg.max_version  <= i_cfg_data[7:0];
                pad_pkg::CFG_NICK_MAX_LEN: r_cfg.nick_max_len <= i_cfg_data[7:0];
                pad_pkg::CFG_MAX_NAME_LEN: r_cfg.max_name_len <= i_cfg_data;
                default: ; // unknown index: drop the write
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pad_parser.sv =====
// ----------------------------------------------------------------------------
// pad_parser
// Parse state registers and the one-byte step logic.
// ----------------------------------------------------------------------------
`default_nettype none

module pad_parser #(
    parameter int MAX_DIGITS = pad_pkg::MAX_DIGITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    input  pad_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output pad_pkg::t_result o_res
);

    localparam int CW = $clog2(MAX_DIGITS);
    localparam logic [CW:0] DIGIT_LIMIT = (CW+1)'(MAX_DIGITS);

    pad_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_tag,   n_tag;
    logic [CW-1:0]   r_cnt,   n_cnt;
    logic [16:0]     r_acc,   n_acc;
    logic [7:0]      r_ver,   n_ver;
    logic [15:0]     r_rc,    n_rc;
    logic [15:0]     r_id,    n_id;
    logic            r_disc,  n_disc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pad_pkg::PH_HEADER;
            r_tag   <= '0;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_ver   <= '0;
            r_rc    <= '0;
            r_id    <= '0;
            r_disc  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_tag   <= n_tag;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_ver   <= n_ver;
            r_rc    <= n_rc;
            r_id    <= n_id;
            r_disc  <= n_disc;
        end
    end

    always_comb begin
        logic            is_dig;
        logic [3:0]      dval;
        logic [20:0]     prod;
        logic [16:0]     dig_acc;
        logic            dig_hit;
        logic [2:0]      tlen;
        logic [2:0]      tpos;
        pad_pkg::t_phase tnext;
        logic [15:0]     tag_rc;
        logic            tag_more;
        logic [15:0]     rc_dec;
        pad_pkg::t_err   err;
        logic            ok;
        logic            ev;
        pad_pkg::t_event kind;
        logic [15:0]     val;
        logic            same;
        logic            closing;

        n_phase = r_phase;
        n_tag   = r_tag;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_ver   = r_ver;
        n_rc    = r_rc;
        n_id    = r_id;
        n_disc  = r_disc;
        err     = pad_pkg::ERR_NONE;
        ok      = 1'b0;
        ev      = 1'b0;
        kind    = pad_pkg::EV_VERSION;
        val     = '0;
        same    = 1'b0;

        // Digit step: acc*10 + digit, saturating at 17 bits
        is_dig  = (i_byte >= pad_pkg::CH_ZERO) && (i_byte <= pad_pkg::CH_NINE);
        dval    = i_byte[3:0];
        prod    = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {17'd0, dval};
        dig_acc = (prod > {4'd0, pad_pkg::ACC_MAX}) ? pad_pkg::ACC_MAX : prod[16:0];
        dig_hit = ({1'b0, r_cnt} + (CW+1)'(1)) >= DIGIT_LIMIT;

        // Tag step for whichever tag phase is active
        case (r_phase)
            pad_pkg::PH_PORT_TAG: begin
                tlen  = pad_pkg::PORT_TAG_LEN;
                tnext = pad_pkg::PH_PORT_NUM;
            end
            pad_pkg::PH_NICK_TAG: begin
                tlen  = pad_pkg::NICK_TAG_LEN;
                tnext = pad_pkg::PH_NICK;
            end
            default: begin
                tlen  = pad_pkg::HDR_TAG_LEN;
                tnext = pad_pkg::PH_VERSION;
            end
        endcase
        tpos     = (r_tag < tlen) ? r_tag : tlen - 3'd1;
        tag_rc   = (i_byte != pad_pkg::tag_byte(r_phase, tpos)) ? 16'd1 : r_rc;
        tag_more = ({1'b0, tpos} + 4'd1) < {1'b0, tlen};

        rc_dec = (r_rc != 16'd0) ? r_rc - 16'd1 : r_rc;

        unique case (r_phase)
            pad_pkg::PH_VERSION: begin
                if (is_dig) begin
                    n_acc = dig_acc;
                    if (dig_hit) begin
                        if (!i_last) err = pad_pkg::ERR_MALF;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end else if (r_acc == 17'd0 || r_acc > {9'd0, i_cfg.max_version}
                             || i_byte != pad_pkg::CH_SEMI) begin
                    err = pad_pkg::ERR_MALF;
                end else begin
                    n_ver   = r_acc[7:0];
                    ev      = 1'b1;
                    kind    = pad_pkg::EV_VERSION;
                    val     = {8'd0, r_acc[7:0]};
                    n_phase = (r_acc[7:0] >= 8'd4) ? pad_pkg::PH_ID : pad_pkg::PH_PORT_TAG;
                    n_tag   = '0;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_rc    = '0;
                end
            end
            pad_pkg::PH_ID: begin
                if (is_dig) begin
                    n_acc = dig_acc;
                    if (dig_hit) begin
                        if (!i_last) err = pad_pkg::ERR_MALF;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end else if (r_acc > pad_pkg::U16_MAX || i_byte != pad_pkg::CH_SEMI) begin
                    err = pad_pkg::ERR_MALF;
                end else begin
                    same    = (r_acc[15:0] == r_id);
                    n_id    = r_acc[15:0];
                    ev      = 1'b1;
                    kind    = pad_pkg::EV_ID;
                    val     = r_acc[15:0];
                    n_phase = pad_pkg::PH_PORT_TAG;
                    n_tag   = '0;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_rc    = '0;
                end
            end
            pad_pkg::PH_PORT_NUM: begin
                if (is_dig) begin
                    n_acc = dig_acc;
                    if (dig_hit) begin
                        if (!i_last) err = pad_pkg::ERR_MALF;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end else if (r_acc == 17'd0 || r_acc > pad_pkg::U16_MAX
                             || i_byte != pad_pkg::CH_SEMI) begin
                    err = pad_pkg::ERR_MALF;
                end else begin
                    ev      = 1'b1;
                    kind    = pad_pkg::EV_PORT;
                    val     = r_acc[15:0];
                    n_phase = (r_ver >= 8'd3) ? pad_pkg::PH_NICK_TAG : pad_pkg::PH_DICT_START;
                    n_tag   = '0;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_rc    = '0;
                end
            end
            pad_pkg::PH_NICK: begin
                if (i_byte == pad_pkg::CH_SEMI) begin
                    ev      = 1'b1;
                    kind    = pad_pkg::EV_NICK_END;
                    val     = r_rc;
                    n_phase = pad_pkg::PH_DICT_START;
                    n_tag   = '0;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_rc    = '0;
                end else if (i_byte == 8'h00 || r_rc >= {8'd0, i_cfg.nick_max_len}) begin
                    err = pad_pkg::ERR_MALF;
                end else begin
                    ev   = 1'b1;
                    kind = pad_pkg::EV_NICK_BYTE;
                    val  = {8'd0, i_byte};
                    n_rc = r_rc + 16'd1;
                end
            end
            pad_pkg::PH_DICT_START: begin
                if (i_byte != pad_pkg::CH_DICT) begin
                    err = pad_pkg::ERR_MALF;
                end else begin
                    n_phase = pad_pkg::PH_DICT;
                    n_tag   = '0;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_rc    = '0;
                end
            end
            pad_pkg::PH_DICT: begin
                if (i_byte == pad_pkg::CH_END) begin
                    ok = 1'b1;
                end else if (is_dig) begin
                    // First length digit: the field starts from zero
                    n_phase = pad_pkg::PH_ENTRY;
                    n_tag   = '0;
                    n_cnt   = CW'(1);
                    n_acc   = {13'd0, dval};
                    n_rc    = '0;
                end else begin
                    err = pad_pkg::ERR_MALF;
                end
            end
            pad_pkg::PH_ENTRY: begin
                if (is_dig) begin
                    n_acc = dig_acc;
                    if (dig_hit) begin
                        if (!i_last) err = pad_pkg::ERR_MALF;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end else if (r_acc == 17'd0 || r_acc > {1'b0, i_cfg.max_name_len}
                             || i_byte != pad_pkg::CH_COLON) begin
                    err = pad_pkg::ERR_MALF;
                end else begin
                    ev      = 1'b1;
                    kind    = pad_pkg::EV_LENGTH;
                    val     = r_acc[15:0];
                    n_phase = pad_pkg::PH_NAME;
                    n_tag   = '0;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_rc    = r_acc[15:0];
                end
            end
            pad_pkg::PH_NAME: begin
                ev   = 1'b1;
                kind = pad_pkg::EV_NAME_BYTE;
                val  = {8'd0, i_byte};
                n_rc = rc_dec;
                if (rc_dec == 16'd0) begin
                    n_phase = pad_pkg::PH_DICT;
                    n_tag   = '0;
                    n_cnt   = '0;
                    n_acc   = '0;
                end
            end
            default: begin
                // Header, port tag and nick tag; unused codes fall back to the header
                if (r_phase != pad_pkg::PH_PORT_TAG && r_phase != pad_pkg::PH_NICK_TAG) begin
                    n_phase = pad_pkg::PH_HEADER;
                end
                n_rc = tag_rc;
                if (tag_more) begin
                    n_tag = tpos + 3'd1;
                end else if (!i_last) begin
                    if (tag_rc != 16'd0) begin
                        err = pad_pkg::ERR_MALF;
                    end else begin
                        n_phase = tnext;
                        n_tag   = '0;
                        n_cnt   = '0;
                        n_acc   = '0;
                        n_rc    = '0;
                    end
                end
            end
        endcase

        // The last byte ends an unfinished message as truncated
        if (!ok && err == pad_pkg::ERR_NONE && i_last) begin
            err = pad_pkg::ERR_TRUNC;
        end
        closing = ok || (err != pad_pkg::ERR_NONE);

        if (closing) begin
            if (i_last) begin
                n_phase = pad_pkg::PH_HEADER;
                n_tag   = '0;
                n_cnt   = '0;
                n_acc   = '0;
                n_rc    = '0;
            end else begin
                n_disc = 1'b1;
            end
        end

        o_res_valid     = closing || ev;
        o_res.kind      = closing ? (ok ? pad_pkg::EV_OK : pad_pkg::EV_ERROR) : kind;
        o_res.value     = closing ? 16'd0 : val;
        o_res.err       = err;
        o_res.same_peer = closing ? 1'b0 : same;
        o_res.msg_end   = closing;

        // Drop trailing bytes through the last one, then restart at the header
        if (r_disc) begin
            n_phase     = r_phase;
            n_tag       = r_tag;
            n_cnt       = r_cnt;
            n_acc       = r_acc;
            n_ver       = r_ver;
            n_rc        = r_rc;
            n_id        = r_id;
            n_disc      = 1'b1;
            o_res_valid = 1'b0;
            if (i_last) begin
                n_disc  = 1'b0;
                n_phase = pad_pkg::PH_HEADER;
                n_tag   = '0;
                n_cnt   = '0;
                n_acc   = '0;
                n_rc    = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pad_out_queue.sv =====
// ----------------------------------------------------------------------------
// pad_out_queue
// Two-word result queue between the parser and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module pad_out_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  pad_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  wire logic        i_pop,
    output pad_pkg::t_result o_data
);

    pad_pkg::t_result r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

`default_nettype wire

// ===== rtl/peer_announce_datagram_parser.sv =====
// ----------------------------------------------------------------------------
// peer_announce_datagram_parser
// Byte-serial parser for peer announcement datagrams.
// ----------------------------------------------------------------------------
// Feed one datagram byte per word on the slave stream, with tlast on the final
// byte of the receive buffer. The block takes one byte every clock cycle: the
// whole step for a byte (tag match, decimal digit with saturation, limit
// checks) is one pass of logic over the parse state registers, and its result
// word lands in a two-word output queue, which registers it for the master
// stream. Bytes that give no result (tag bytes, digits, trailing bytes after a
// closing event) go through without using queue space. The input stalls only
// while the output queue holds two words that the downstream side has not
// taken. Each master word carries an event kind in tuser; ok and error events
// close a message and raise tlast. After a closing event that is not on the
// buffer's last byte, drop the rest of the buffer up to and including the last
// byte, then restart at the header. Write configuration only while the block
// is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_announce_datagram_parser #(
    parameter int MAX_DIGITS = pad_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    // Byte input
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
    input  wire logic                             s_axis_tlast,  // last_byte

    // Result output
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [15:0] field_value, [17:16] error_kind, [18] same_peer, [23:19] zero
    output logic [23:0]                           m_axis_tdata,
    output logic [3:0]                            m_axis_tuser,  // [3:0] event_kind
    output logic                                  m_axis_tlast,  // message_end

    // Configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pad_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [pad_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    pad_pkg::t_cfg    cfg;
    pad_pkg::t_result res;
    pad_pkg::t_result q_data;
    logic             res_valid;
    logic             q_full;
    logic             in_accept;

    // Hold the input while the queue is full
    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    pad_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pad_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    pad_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept && res_valid),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (m_axis_tvalid),
        .i_pop   (m_axis_tready),
        .o_data  (q_data)
    );

    // Pack the result word, first field in the lowest bits
    assign m_axis_tdata = {5'd0, q_data.same_peer, q_data.err, q_data.value};
    assign m_axis_tuser = q_data.kind;
    assign m_axis_tlast = q_data.msg_end;

endmodule

`default_nettype wire
